>>> hdl/chwf_pkg.sv
// Shared definitions for the chunk head word finder: tag codes, chunk types,
// the head rule tables and the microcode word layout.
// No dependencies; imported by chunk_head_word_finder_top and chwf_checker.
package chwf_pkg;

    // Sentence buffer size; positions are 8 bits, so at most 256 entries are kept
    localparam int MAX_WORDS = 256;
    localparam int BUF_DEPTH = (MAX_WORDS < 256) ? MAX_WORDS : 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // Item widths
    localparam int POS_W  = 8;
    localparam int TAG_W  = 6;
    localparam int TYPE_W = 4;

    // Part-of-speech and phrase tag codes
    localparam logic [TAG_W-1:0] TAG_CC     = 6'd1;
    localparam logic [TAG_W-1:0] TAG_CD     = 6'd2;
    localparam logic [TAG_W-1:0] TAG_DT     = 6'd3;
    localparam logic [TAG_W-1:0] TAG_FW     = 6'd4;
    localparam logic [TAG_W-1:0] TAG_IN     = 6'd5;
    localparam logic [TAG_W-1:0] TAG_JJ     = 6'd6;
    localparam logic [TAG_W-1:0] TAG_JJR    = 6'd7;
    localparam logic [TAG_W-1:0] TAG_JJS    = 6'd8;
    localparam logic [TAG_W-1:0] TAG_LST    = 6'd9;
    localparam logic [TAG_W-1:0] TAG_MD     = 6'd10;
    localparam logic [TAG_W-1:0] TAG_NN     = 6'd11;
    localparam logic [TAG_W-1:0] TAG_NNS    = 6'd12;
    localparam logic [TAG_W-1:0] TAG_NNP    = 6'd13;
    localparam logic [TAG_W-1:0] TAG_NNPS   = 6'd14;
    localparam logic [TAG_W-1:0] TAG_POS    = 6'd15;
    localparam logic [TAG_W-1:0] TAG_RB     = 6'd16;
    localparam logic [TAG_W-1:0] TAG_RBR    = 6'd17;
    localparam logic [TAG_W-1:0] TAG_RBS    = 6'd18;
    localparam logic [TAG_W-1:0] TAG_RP     = 6'd19;
    localparam logic [TAG_W-1:0] TAG_TO     = 6'd20;
    localparam logic [TAG_W-1:0] TAG_VB     = 6'd21;
    localparam logic [TAG_W-1:0] TAG_VBD    = 6'd22;
    localparam logic [TAG_W-1:0] TAG_VBG    = 6'd23;
    localparam logic [TAG_W-1:0] TAG_VBN    = 6'd24;
    localparam logic [TAG_W-1:0] TAG_VBP    = 6'd25;
    localparam logic [TAG_W-1:0] TAG_VBZ    = 6'd26;
    localparam logic [TAG_W-1:0] TAG_DOLLAR = 6'd27;
    localparam logic [TAG_W-1:0] TAG_COLON  = 6'd28;
    localparam logic [TAG_W-1:0] TAG_QP     = 6'd29;
    localparam logic [TAG_W-1:0] TAG_ADVP   = 6'd30;
    localparam logic [TAG_W-1:0] TAG_ADJP   = 6'd31;
    localparam logic [TAG_W-1:0] TAG_NP     = 6'd32;
    localparam logic [TAG_W-1:0] TAG_SBAR   = 6'd33;
    localparam logic [TAG_W-1:0] TAG_NX     = 6'd34;
    localparam logic [TAG_W-1:0] TAG_PRN    = 6'd35;
    localparam logic [TAG_W-1:0] TAG_VP     = 6'd36;

    // Chunk types; codes 12..15 are unused and behave like INTJ
    typedef enum logic [TYPE_W-1:0] {
        CT_ADJP  = 4'd0,
        CT_ADVP  = 4'd1,
        CT_CONJP = 4'd2,
        CT_INTJ  = 4'd3,
        CT_LST   = 4'd4,
        CT_NP    = 4'd5,
        CT_O     = 4'd6,
        CT_PP    = 4'd7,
        CT_PRT   = 4'd8,
        CT_SBAR  = 4'd9,
        CT_UCP   = 4'd10,
        CT_VP    = 4'd11
    } t_chunk_type;

    // Input tdata layout, last field in the low bits; the command rides in tuser
    typedef struct packed {
        logic [5:0]        pad;
        logic [TYPE_W-1:0] chunk_type;
        logic [TAG_W-1:0]  tag_code;
        logic [POS_W-1:0]  end_index;
        logic [POS_W-1:0]  start_index;
    } t_in_item;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Priority tag lists, back to back; entries past the last list read as 0
    localparam int ROM_AW   = 7;
    localparam int ROM_USED = 74;
    localparam logic [TAG_W-1:0] RULE_ROM [ROM_USED] = '{
        // ADJP
        TAG_NNS, TAG_QP, TAG_NN, TAG_DOLLAR, TAG_ADVP, TAG_JJ, TAG_VBN, TAG_VBG, TAG_ADJP,
        TAG_JJR, TAG_NP, TAG_JJS, TAG_DT, TAG_FW, TAG_RBR, TAG_RBS, TAG_SBAR, TAG_RB,
        // ADVP
        TAG_RB, TAG_RBR, TAG_RBS, TAG_FW, TAG_ADVP, TAG_TO, TAG_CD, TAG_JJR, TAG_JJ,
        TAG_IN, TAG_NP, TAG_JJS, TAG_NN,
        // CONJP
        TAG_CC, TAG_RB, TAG_IN,
        // LST
        TAG_LST, TAG_COLON,
        // NP lists
        TAG_NN, TAG_NNP, TAG_NNPS, TAG_NNS, TAG_NX, TAG_POS, TAG_JJR,
        TAG_NP,
        TAG_DOLLAR, TAG_ADJP, TAG_PRN,
        TAG_CD,
        TAG_JJ, TAG_JJS, TAG_RB, TAG_QP,
        // PP
        TAG_IN, TAG_TO, TAG_VBG, TAG_VBN, TAG_RP, TAG_FW,
        // PRT
        TAG_RP,
        // SBAR
        TAG_IN, TAG_DT,
        // VP
        TAG_TO, TAG_VBD, TAG_VBN, TAG_MD, TAG_VBZ, TAG_VB, TAG_VBG, TAG_VBP, TAG_VP,
        TAG_ADJP, TAG_NN, TAG_NNS, TAG_NP
    };

    function automatic logic [TAG_W-1:0] rom_tag(input logic [ROM_AW-1:0] a);
        return (32'(a) < ROM_USED) ? RULE_ROM[a] : '0;
    endfunction

    // One segment: a slice of the tag ROM plus its scan direction
    typedef struct packed {
        logic [ROM_AW-1:0] off;
        logic [4:0]        len;
        logic              rtl;
    } t_segment;

    localparam int NUM_SEG = 13;
    localparam int SEG_W   = 4;
    localparam t_segment SEG_TABLE [NUM_SEG] = '{
        '{7'd0,  5'd18, 1'b0}, '{7'd18, 5'd13, 1'b1}, '{7'd31, 5'd3, 1'b1},
        '{7'd34, 5'd2,  1'b1}, '{7'd36, 5'd7,  1'b1}, '{7'd43, 5'd1, 1'b0},
        '{7'd44, 5'd3,  1'b1}, '{7'd47, 5'd1,  1'b1}, '{7'd48, 5'd4, 1'b1},
        '{7'd52, 5'd6,  1'b1}, '{7'd58, 5'd1,  1'b1}, '{7'd59, 5'd2, 1'b0},
        '{7'd61, 5'd13, 1'b0}
    };

    // Per chunk type: first segment, number of segments, fallback to end
    typedef struct packed {
        logic [SEG_W-1:0] first;
        logic [2:0]       count;
        logic             fb_end;
    } t_rule;

    function automatic t_rule rule_of(input logic [TYPE_W-1:0] ct);
        t_rule r;
        r = '{first: '0, count: '0, fb_end: 1'b0};
        case (ct)
            CT_ADJP:  r = '{first: 4'd0,  count: 3'd1, fb_end: 1'b0};
            CT_ADVP:  r = '{first: 4'd1,  count: 3'd1, fb_end: 1'b1};
            CT_CONJP: r = '{first: 4'd2,  count: 3'd1, fb_end: 1'b1};
            CT_LST:   r = '{first: 4'd3,  count: 3'd1, fb_end: 1'b1};
            CT_NP:    r = '{first: 4'd4,  count: 3'd5, fb_end: 1'b1};
            CT_PP:    r = '{first: 4'd9,  count: 3'd1, fb_end: 1'b1};
            CT_PRT:   r = '{first: 4'd10, count: 3'd1, fb_end: 1'b1};
            CT_SBAR:  r = '{first: 4'd11, count: 3'd1, fb_end: 1'b0};
            CT_UCP:   r = '{first: 4'd0,  count: 3'd0, fb_end: 1'b1};
            CT_VP:    r = '{first: 4'd12, count: 3'd1, fb_end: 1'b0};
            default:  r = '{first: 4'd0,  count: 3'd0, fb_end: 1'b0};
        endcase
        return r;
    endfunction

    // Microcode: datapath operation, jump conditions and step addresses
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_POSCHK,
        OP_SEG_LOAD,
        OP_TAG_LOAD,
        OP_SCAN,
        OP_FALLBACK,
        OP_OUT,
        OP_SEG_NEXT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NOT_QUERY,
        C_POS_HIT,
        C_SEG_DONE,
        C_TAG_DONE,
        C_SPAN_EMPTY,
        C_SCAN_HIT,
        C_SCAN_END
    } t_cond;

    localparam int UPC_W = 3;

    localparam logic [UPC_W-1:0] UPC_IDLE     = 3'd0;
    localparam logic [UPC_W-1:0] UPC_POSCHK   = 3'd1;
    localparam logic [UPC_W-1:0] UPC_SEG      = 3'd2;
    localparam logic [UPC_W-1:0] UPC_TAG      = 3'd3;
    localparam logic [UPC_W-1:0] UPC_SCAN     = 3'd4;
    localparam logic [UPC_W-1:0] UPC_FALLBACK = 3'd5;
    localparam logic [UPC_W-1:0] UPC_OUT      = 3'd6;
    localparam logic [UPC_W-1:0] UPC_SEG_NEXT = 3'd7;

    // Next step: cond_a ? tgt_a : cond_b ? tgt_b : tgt_else
    typedef struct packed {
        t_uop             op;
        t_cond            cond_a;
        logic [UPC_W-1:0] tgt_a;
        t_cond            cond_b;
        logic [UPC_W-1:0] tgt_b;
        logic [UPC_W-1:0] tgt_else;
    } t_uword;

    // Output busy shares the C_NEVER code, which is true only in the output step while busy
    localparam t_cond C_OUT_BUSY = C_NEVER;

    localparam t_uword UCODE [2**UPC_W] = '{
        '{OP_IDLE,     C_NOT_QUERY,  UPC_IDLE,   C_NEVER,      UPC_IDLE, UPC_POSCHK},
        '{OP_POSCHK,   C_POS_HIT,    UPC_OUT,    C_NEVER,      UPC_IDLE, UPC_SEG},
        '{OP_SEG_LOAD, C_SEG_DONE,   UPC_FALLBACK, C_NEVER,    UPC_IDLE, UPC_TAG},
        '{OP_TAG_LOAD, C_TAG_DONE,   UPC_SEG_NEXT, C_SPAN_EMPTY, UPC_TAG, UPC_SCAN},
        '{OP_SCAN,     C_SCAN_HIT,   UPC_OUT,    C_SCAN_END,   UPC_TAG,  UPC_SCAN},
        '{OP_FALLBACK, C_NEVER,      UPC_IDLE,   C_NEVER,      UPC_IDLE, UPC_OUT},
        '{OP_OUT,      C_OUT_BUSY,   UPC_OUT,    C_NEVER,      UPC_IDLE, UPC_IDLE},
        '{OP_SEG_NEXT, C_NEVER,      UPC_IDLE,   C_NEVER,      UPC_IDLE, UPC_SEG}
    };

endpackage

>>> hdl/chunk_head_word_finder_top.sv
// Chunk head word finder: tag buffer, head rule sequencer and output register.
// Depends on chwf_pkg (tag codes, rule tables, microcode ROM).
//
// Write items (cmd 0 in tuser) store one tag; the block is ready again on the next
// cycle. A query (cmd 1) walks the chunk type's rule under a small microprogram, and
// the single read port of the tag buffer delivers one word position per cycle; INTJ,
// O, UCP and unused types reach the fallback without a scan. The result waits in an
// output register, so a new item is taken while the previous head index is unread.
// No clearing pass after reset: the buffer must be written before it is queried.
module chunk_head_word_finder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // start_index[7:0], end_index[15:8], tag_code[21:16], chunk_type[25:22]
    input  logic [31:0] i_s_axis_tdata,
    // cmd[0]
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // head_index[7:0]
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready
);
    import chwf_pkg::*;

    // Sequencer and datapath registers
    logic [UPC_W-1:0]  r_upc;
    logic [POS_W-1:0]  r_lo;
    logic [POS_W-1:0]  r_hi;
    logic [TYPE_W-1:0] r_type;
    logic              r_fb_end;
    logic [SEG_W-1:0]  r_seg;
    logic [2:0]        r_seg_left;
    logic [ROM_AW-1:0] r_tag_ptr;
    logic [4:0]        r_tag_left;
    logic              r_rtl;
    logic [TAG_W-1:0]  r_want;
    logic [POS_W-1:0]  r_cmp_pos;
    logic [POS_W-1:0]  r_left;
    logic [POS_W-1:0]  r_result;
    logic [POS_W-1:0]  r_out_data;
    logic              r_out_valid;

    // Tag buffer with one write and one registered read port
    logic [TAG_W-1:0]  r_mem [BUF_DEPTH];
    logic [TAG_W-1:0]  r_rd;
    logic              r_rd_ok;

    t_in_item          in_item;
    t_uword            uw;
    t_rule             in_rule;
    t_segment          cur_seg;
    logic              in_accept;
    logic              out_busy;
    logic              wr_en;
    logic [POS_W-1:0]  rd_pos;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  step_pos;
    logic [7:0]        cond_vec;
    logic              hit_a;
    logic              hit_b;
    logic [UPC_W-1:0]  n_upc;

    assign in_item   = t_in_item'(i_s_axis_tdata);
    assign uw        = UCODE[r_upc];
    assign in_rule   = rule_of(in_item.chunk_type);
    assign cur_seg   = SEG_TABLE[r_seg];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_busy  = r_out_valid && !i_m_axis_tready;
    assign wr_en     = in_accept && (i_s_axis_tuser == CMD_WRITE)
                       && (32'(in_item.start_index) < MAX_WORDS);

    assign o_s_axis_tready = (uw.op == OP_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Read address: span end at accept, first scan word, then one step per cycle
    assign first_pos = r_rtl ? r_hi : r_lo;
    assign step_pos  = r_rtl ? (r_cmp_pos - 1'b1) : (r_cmp_pos + 1'b1);

    always_comb begin
        case (uw.op)
            OP_IDLE:     rd_pos = in_item.end_index;
            OP_TAG_LOAD: rd_pos = SEG_TABLE[r_seg].rtl ? r_hi : r_lo;
            OP_SCAN:     rd_pos = step_pos;
            default:     rd_pos = r_cmp_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[in_item.start_index[BUF_AW-1:0]] <= in_item.tag_code;
        end
        r_rd    <= r_mem[rd_pos[BUF_AW-1:0]];
        r_rd_ok <= (32'(rd_pos) < MAX_WORDS);
    end

    // Jump conditions, one bit per condition code
    always_comb begin
        cond_vec               = '0;
        cond_vec[C_NEVER]      = (uw.op == OP_OUT) && out_busy;
        cond_vec[C_NOT_QUERY]  = !(in_accept && (i_s_axis_tuser == CMD_QUERY));
        cond_vec[C_POS_HIT]    = (r_type == CT_NP) && r_rd_ok && (r_rd == TAG_POS);
        cond_vec[C_SEG_DONE]   = (r_seg_left == '0);
        cond_vec[C_TAG_DONE]   = (r_tag_left == '0);
        cond_vec[C_SPAN_EMPTY] = (r_lo > r_hi);
        cond_vec[C_SCAN_HIT]   = r_rd_ok && (r_rd == r_want);
        cond_vec[C_SCAN_END]   = (r_left == '0);
    end

    assign hit_a = cond_vec[uw.cond_a];
    assign hit_b = cond_vec[uw.cond_b];
    assign n_upc = hit_a ? uw.tgt_a : (hit_b ? uw.tgt_b : uw.tgt_else);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Datapath driven by the current control word
    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_IDLE: begin
                r_lo       <= in_item.start_index;
                r_hi       <= in_item.end_index;
                r_type     <= in_item.chunk_type;
                r_fb_end   <= in_rule.fb_end;
                r_seg      <= in_rule.first;
                r_seg_left <= in_rule.count;
            end
            OP_POSCHK: begin
                r_result <= r_hi;
            end
            OP_SEG_LOAD: begin
                r_tag_ptr  <= cur_seg.off;
                r_tag_left <= cur_seg.len;
                r_rtl      <= cur_seg.rtl;
            end
            OP_TAG_LOAD: begin
                if (r_tag_left != '0) begin
                    r_want     <= rom_tag(r_tag_ptr);
                    r_tag_ptr  <= r_tag_ptr + 1'b1;
                    r_tag_left <= r_tag_left - 1'b1;
                    r_cmp_pos  <= first_pos;
                    r_left     <= r_hi - r_lo;
                end
            end
            OP_SCAN: begin
                r_result <= r_cmp_pos;
                if (r_left != '0) begin
                    r_cmp_pos <= step_pos;
                    r_left    <= r_left - 1'b1;
                end
            end
            OP_FALLBACK: begin
                r_result <= r_fb_end ? r_hi : r_lo;
            end
            OP_SEG_NEXT: begin
                r_seg      <= (r_seg == SEG_W'(NUM_SEG - 1)) ? '0 : r_seg + 1'b1;
                r_seg_left <= r_seg_left - 1'b1;
            end
            default: begin
                r_result <= r_result;
            end
        endcase
    end

    // Output register: loaded from the result, freed by the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((uw.op == OP_OUT) && !out_busy) begin
            r_out_valid <= 1'b1;
            r_out_data  <= r_result;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

>>> hdl/chwf_checker.sv
// Port-level checks for the chunk head word finder, bound to the top level.
// Depends on chwf_pkg for the command codes; attaches to chunk_head_word_finder_top.
module chwf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic [31:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready
);
    import chwf_pkg::*;

    // Reset leaves the block ready with no result pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("block not idle after reset");

    // A query occupies the sequencer for at least the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_QUERY))
        |=> !o_s_axis_tready)
        else $error("ready after query transfer");

    // After a tag write the block is ready again on the next cycle
    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_WRITE))
        |=> o_s_axis_tready)
        else $error("not ready after write transfer");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result dropped or changed while stalled");

endmodule

bind chunk_head_word_finder_top chwf_checker u_chwf_checker (.*);
